// ----- rtl/glu_pkg.sv -----
// Shared types and constants for the gcd/lcm unit.
package glu_pkg;

	// Port widths fixed by the command interface.
	localparam int PORT_OPERAND_BITS = 32;
	localparam int ANSWER_BITS       = 64;

	// Depth of the queue between the front and back ends.
	localparam int QUEUE_DEPTH = 2;

	// Command codes.
	localparam logic CMD_GCD = 1'b0;
	localparam logic CMD_LCM = 1'b1;

	// Classification that the front end attaches to each queued beat.
	typedef struct packed {
		logic lcm;     // least common multiple requested
		logic trivial; // an operand is zero, so no iteration is needed
	} glu_ctrl_t;

	localparam int CTRL_BITS = $bits(glu_ctrl_t);

endpackage

// ----- rtl/glu_front.sv -----
// Front end: accepts command beats, masks the operands and classifies them.
module glu_front #(
	parameter int OPERAND_BITS = 32,
	parameter int ENTRY_BITS   = glu_pkg::CTRL_BITS + 2 * OPERAND_BITS
) (
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  command,
	input  logic [glu_pkg::PORT_OPERAND_BITS-1:0] operand_a,
	input  logic [glu_pkg::PORT_OPERAND_BITS-1:0] operand_b,
	input  logic                                  queue_full,
	output logic                                  push,
	output logic [ENTRY_BITS-1:0]                 push_data
);
	import glu_pkg::*;

	logic [OPERAND_BITS-1:0] a_m;
	logic [OPERAND_BITS-1:0] b_m;
	glu_ctrl_t               ctrl;

	// Only the low operand bits take part in the computation.
	assign a_m = operand_a[OPERAND_BITS-1:0];
	assign b_m = operand_b[OPERAND_BITS-1:0];

	// A zero operand settles the answer without any iteration.
	always_comb begin
		ctrl.lcm     = (command == CMD_LCM);
		ctrl.trivial = (a_m == '0) || (b_m == '0);
	end

	// A beat is taken whenever the queue has room.
	assign busy      = queue_full;
	assign push      = start && !queue_full;
	assign push_data = {ctrl, a_m, b_m};

endmodule

// ----- rtl/glu_queue.sv -----
// Short queue that decouples the front end from the back end.
module glu_queue #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import glu_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] wr_cnt;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[0];

	// The new beat lands just after whatever remains once the head leaves.
	assign wr_cnt = count_q - CNT_W'(pop);

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= wr_cnt + CNT_W'(push);
		end
	end

	// Slots shift toward the head on a pop; the head is always slot zero.
	// The slot that takes a new beat would otherwise shift in an empty slot.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (push && (wr_cnt == CNT_W'(i))) begin
				slot_q[i] <= push_data;
			end else if (pop && (i < QUEUE_DEPTH - 1)) begin
				slot_q[i] <= slot_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
			end
		end
	end

endmodule

// ----- rtl/glu_back.sv -----
// Back end: binary gcd iteration, restoring divide and final multiply.
module glu_back #(
	parameter int OPERAND_BITS = 32,
	parameter int ENTRY_BITS   = glu_pkg::CTRL_BITS + 2 * OPERAND_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            queue_empty,
	input  logic [ENTRY_BITS-1:0]           pop_data,
	output logic                            pop,
	output logic                            done,
	output logic [glu_pkg::ANSWER_BITS-1:0] answer
);
	import glu_pkg::*;

	localparam int N     = OPERAND_BITS;
	localparam int CNT_W = $clog2(N + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_GCD  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_MUL  = 2'd3;

	logic [1:0]           state_q;
	logic                 done_q;
	logic [ANSWER_BITS-1:0] answer_q;
	logic                 lcm_q;
	logic [N-1:0]         a_q;
	logic [N-1:0]         b_q;
	logic [N-1:0]         x_q;
	logic [N-1:0]         y_q;
	logic [CNT_W-1:0]     k_q;
	logic [N-1:0]         g_q;
	logic [N-1:0]         quot_q;
	logic [N-1:0]         rem_q;
	logic [CNT_W-1:0]     cnt_q;

	glu_ctrl_t            in_ctrl;
	logic [N-1:0]         in_a;
	logic [N-1:0]         in_b;
	logic [N-1:0]         gcd_val;
	logic [N:0]           rem_sh;
	logic [N:0]           rem_diff;
	logic [2*N-1:0]       prod;

	// Unpack the queue head.
	assign in_ctrl = glu_ctrl_t'(pop_data[ENTRY_BITS-1:2*N]);
	assign in_a    = pop_data[2*N-1:N];
	assign in_b    = pop_data[N-1:0];

	assign pop    = (state_q == S_IDLE) && !queue_empty;
	assign done   = done_q;
	assign answer = answer_q;

	// Gcd once one value reaches zero: the other value with the shared twos restored.
	assign gcd_val = (x_q | y_q) << k_q;

	// One restoring divide step: bring in the next dividend bit and trial subtract.
	assign rem_sh   = {rem_q, quot_q[N-1]};
	assign rem_diff = rem_sh - {1'b0, g_q};

	// Cofactor of a times b gives the lcm.
	assign prod = quot_q * b_q;

	// Sequencer state and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (in_ctrl.trivial) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if ((x_q == '0) || (y_q == '0)) begin
						if (lcm_q) begin
							state_q <= S_DIV;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					lcm_q <= in_ctrl.lcm;
					a_q   <= in_a;
					b_q   <= in_b;
					x_q   <= in_a;
					y_q   <= in_b;
					k_q   <= '0;
					// A zero operand: gcd is the other one, lcm is zero.
					if (in_ctrl.lcm) begin
						answer_q <= '0;
					end else begin
						answer_q <= ANSWER_BITS'(in_a | in_b);
					end
				end
			end
			S_GCD: begin
				if ((x_q == '0) || (y_q == '0)) begin
					g_q      <= gcd_val;
					answer_q <= ANSWER_BITS'(gcd_val);
					quot_q   <= a_q;
					rem_q    <= '0;
					cnt_q    <= CNT_W'(N);
				end else begin
					// Binary gcd step.
					priority if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + CNT_W'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= (x_q - y_q) >> 1;
					end else begin
						y_q <= (y_q - x_q) >> 1;
					end
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (!rem_diff[N]) begin
					rem_q  <= rem_diff[N-1:0];
					quot_q <= {quot_q[N-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[N-1:0];
					quot_q <= {quot_q[N-2:0], 1'b0};
				end
			end
			S_MUL: begin
				answer_q <= ANSWER_BITS'(prod);
			end
			default: begin
				answer_q <= answer_q;
			end
		endcase
	end

endmodule

// ----- rtl/gcd_lcm_unit_top.sv -----
// A command with a zero operand is answered straight from the idle state through done_q and answer_q.
// Gcd runs the binary gcd loop in the back end until one value reaches zero;
// lcm adds OPERAND_BITS restoring divide steps and a final multiply.
// Throughput: one command at a time in the back end; a two-beat queue takes new commands
// while it works, and busy is high only when that queue is full. Done pulses for one cycle.
// Reset (arst_n low) empties the queue and returns the sequencer to idle.
module gcd_lcm_unit_top #(
	parameter int OPERAND_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  command,
	input  logic [glu_pkg::PORT_OPERAND_BITS-1:0] operand_a,
	input  logic [glu_pkg::PORT_OPERAND_BITS-1:0] operand_b,
	output logic                                  done,
	output logic [glu_pkg::ANSWER_BITS-1:0]       answer
);
	import glu_pkg::*;

	localparam int ENTRY_BITS = CTRL_BITS + 2 * OPERAND_BITS;

	logic                  push;
	logic [ENTRY_BITS-1:0] push_data;
	logic                  pop;
	logic [ENTRY_BITS-1:0] pop_data;
	logic                  queue_full;
	logic                  queue_empty;

	// Command intake and classification.
	glu_front #(
		.OPERAND_BITS(OPERAND_BITS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_front (
		.start     (start),
		.busy      (busy),
		.command   (command),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	// Queue between front and back.
	glu_queue #(
		.WIDTH(ENTRY_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	// Iterative gcd/lcm engine.
	glu_back #(
		.OPERAND_BITS(OPERAND_BITS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_empty(queue_empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.done       (done),
		.answer     (answer)
	);

endmodule
